// ===== design/sha256_message_hasher_unit_defines.svh =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i and held off while
// rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_HASHER_UNIT_DEFINES_SVH
`define SHA256_MESSAGE_HASHER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHAMH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHAMH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/shamh_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher package
// Round constants, initial hash values, sequencer states and the SHA-256
// bit functions shared by the hasher.
// ----------------------------------------------------------------------------
package shamh_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned Rounds  = 64;
  localparam int unsigned BlkWds  = 16;
  localparam int unsigned HashWds = 8;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] ROUND_K [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HASH_IV [HashWds] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WT
  } state_e;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    sml_sig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    sml_sig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    choose = (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    majority = (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// ===== design/shamh_if.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher channels
// Valid/ready stream interfaces for the message byte input and the digest
// word output.
// ----------------------------------------------------------------------------
interface shamh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, msg_byte, byte_valid, end_of_message, input ready);
  modport sink   (input valid, msg_byte, byte_valid, end_of_message, output ready);
endinterface

interface shamh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== design/sha256_message_hasher_unit.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Hashes a byte stream with SHA-256 and returns the eight digest words at the
// end of each message. Block words and chaining words live in two memories.
// ----------------------------------------------------------------------------
//  Channel    Dir  Payload                                  Transaction
//  msg_i      in   msg_byte, byte_valid, end_of_message     one byte or empty
//  digest_o   out  digest_word, word_index, last_word       one digest word
//
// A byte that neither completes a block nor ends the message leaves msg_i ready.
// A full block takes three phases: load the working variables from the chain
// memory, 64 rounds at one per cycle, and add back into the chain memory.
// End of message adds a padding pass over up to 16 block words, one or two
// compressions, and per digest word a read, a load and a wait on digest_o ready.
// Reset returns the chaining words to the initial values at once through
// per-entry valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "sha256_message_hasher_unit_defines.svh"

module sha256_message_hasher_unit
  import shamh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  shamh_in_if.sink    msg_i,
  shamh_out_if.source digest_o
);

  // Sequencer and datapath registers.
  state_e      state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bitlen_q, bitlen_d;
  logic        eom_q, eom_d;
  logic        padded_q, padded_d;
  logic        pass2_q, pass2_d;
  logic        first_q, first_d;
  logic        long_q, long_d;
  logic [3:0]  pidx_q, pidx_d;
  logic [7:0]  ch_valid_q, ch_valid_d;
  logic        out_valid_q, out_valid_d;

  logic [31:0] acc_q, acc_d;
  logic [31:0] w_q, w_d;
  logic [31:0] dw_q, dw_d;
  logic [31:0] v_q [8];
  logic [31:0] v_d [8];
  logic [31:0] sched_q [16];
  logic [31:0] sched_d [16];

  // Block word memory.
  logic [31:0] blk_mem [BlkWds];
  logic        blk_we;
  logic [3:0]  blk_waddr;
  logic [31:0] blk_wdata;
  logic [3:0]  blk_raddr;
  logic [31:0] blk_rdata_q;

  // Chaining word memory.
  logic [31:0] ch_mem [HashWds];
  logic        ch_we;
  logic [2:0]  ch_waddr;
  logic [31:0] ch_wdata;
  logic [2:0]  ch_raddr;
  logic [2:0]  ch_raddr_q;
  logic [31:0] ch_rdata_q;
  logic        ch_rvalid_q;
  logic [31:0] ch_rd;

  logic        in_acc;
  logic [4:0]  byte_sh;
  logic [31:0] acc_m;
  logic [5:0]  fill_nx;
  logic [31:0] pad_word;
  logic        len_here;
  logic [31:0] t1;
  logic [31:0] t2;
  logic        out_done;

  always_ff @(posedge clk_i) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wdata;
    end
    blk_rdata_q <= blk_mem[blk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ch_we) begin
      ch_mem[ch_waddr] <= ch_wdata;
    end
    ch_rdata_q  <= ch_mem[ch_raddr];
    ch_rvalid_q <= ch_valid_q[ch_raddr];
    ch_raddr_q  <= ch_raddr;
  end

  // A chaining entry that has not been written since the last digest reads as
  // its initial hash value.
  assign ch_rd = ch_rvalid_q ? ch_rdata_q : HASH_IV[ch_raddr_q];

  assign msg_i.ready          = (state_q == ST_IDLE);
  assign in_acc               = msg_i.valid && msg_i.ready;
  assign digest_o.valid       = out_valid_q;
  assign digest_o.digest_word = dw_q;
  assign digest_o.word_index  = cnt_q[2:0];
  assign digest_o.last_word   = (cnt_q[2:0] == 3'd7);
  assign out_done             = out_valid_q && digest_o.ready;

  // Message bytes are packed big-endian into the word being assembled.
  always_comb begin
    byte_sh = {~fill_q[1:0], 3'b000};
    acc_m   = acc_q;
    acc_m[byte_sh +: 8] = msg_i.msg_byte;
  end

  // Padding word: held bytes, then the 0x80 marker, then zeros; the length
  // occupies the last two words of the final block.
  always_comb begin
    len_here = pass2_q || !long_q;
    pad_word = '0;
    if (first_q) begin
      for (int b = 0; b < 4; b++) begin
        if (2'(b) < fill_q[1:0]) begin
          pad_word[31 - 8 * b -: 8] = acc_q[31 - 8 * b -: 8];
        end else if (2'(b) == fill_q[1:0]) begin
          pad_word[31 - 8 * b -: 8] = PAD_BYTE;
        end
      end
    end else if (len_here && (pidx_q == 4'd14)) begin
      pad_word = bitlen_q[63:32];
    end else if (len_here && (pidx_q == 4'd15)) begin
      pad_word = bitlen_q[31:0];
    end
  end

  assign t1 = v_q[7] + big_sig1(v_q[4]) + choose(v_q[4], v_q[5], v_q[6])
            + ROUND_K[cnt_q] + w_q;
  assign t2 = big_sig0(v_q[0]) + majority(v_q[0], v_q[1], v_q[2]);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    fill_d      = fill_q;
    bitlen_d    = bitlen_q;
    eom_d       = eom_q;
    padded_d    = padded_q;
    pass2_d     = pass2_q;
    first_d     = first_q;
    long_d      = long_q;
    pidx_d      = pidx_q;
    ch_valid_d  = ch_valid_q;
    out_valid_d = out_valid_q;
    acc_d       = acc_q;
    w_d         = w_q;
    dw_d        = dw_q;
    v_d         = v_q;
    sched_d     = sched_q;
    blk_we      = 1'b0;
    blk_waddr   = fill_q[5:2];
    blk_wdata   = acc_m;
    blk_raddr   = 4'd0;
    ch_we       = 1'b0;
    ch_waddr    = 3'(cnt_q - 6'd1);
    ch_wdata    = ch_rd + v_q[0];
    ch_raddr    = cnt_q[2:0];
    fill_nx     = fill_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (msg_i.byte_valid) begin
            acc_d    = acc_m;
            bitlen_d = bitlen_q + 64'd8;
            fill_nx  = fill_q + 6'd1;
            blk_we   = (fill_q[1:0] == 2'd3);
          end
          fill_d   = fill_nx;
          eom_d    = msg_i.end_of_message;
          padded_d = 1'b0;
          pass2_d  = 1'b0;
          if (msg_i.byte_valid && (fill_q == 6'd63)) begin
            state_d = ST_LOAD;
            cnt_d   = '0;
          end else if (msg_i.end_of_message) begin
            state_d  = ST_PAD;
            pidx_d   = fill_nx[5:2];
            first_d  = 1'b1;
            padded_d = 1'b1;
            long_d   = (fill_nx[5:3] == 3'd7);
          end
        end
      end

      ST_PAD: begin
        blk_we    = 1'b1;
        blk_waddr = pidx_q;
        blk_wdata = pad_word;
        first_d   = 1'b0;
        pidx_d    = pidx_q + 4'd1;
        if (pidx_q == 4'd15) begin
          state_d = ST_LOAD;
          cnt_d   = '0;
        end
      end

      ST_LOAD: begin
        // Chain words stream in one per cycle; the first two block words are
        // fetched at the end so that round 0 starts with its word in place.
        cnt_d = cnt_q + 6'd1;
        if (cnt_q != 6'd0) begin
          for (int i = 0; i < 7; i++) begin
            v_d[i] = v_q[i + 1];
          end
          v_d[7] = ch_rd;
        end
        if (cnt_q == 6'd8) begin
          blk_raddr = 4'd1;
          w_d       = blk_rdata_q;
          state_d   = ST_ROUND;
          cnt_d     = '0;
        end
      end

      ST_ROUND: begin
        cnt_d     = cnt_q + 6'd1;
        blk_raddr = 4'(cnt_q + 6'd2);
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        for (int i = 0; i < 15; i++) begin
          sched_d[i] = sched_q[i + 1];
        end
        sched_d[15] = w_q;
        // Word for the next round: from the block memory for the first
        // sixteen, then from the rolling schedule window.
        if (cnt_q < 6'd15) begin
          w_d = blk_rdata_q;
        end else begin
          w_d = sml_sig1(sched_q[15]) + sched_q[10] + sml_sig0(sched_q[2]) + sched_q[1];
        end
        if (cnt_q == 6'd63) begin
          state_d = ST_ADD;
          cnt_d   = '0;
        end
      end

      ST_ADD: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q != 6'd0) begin
          ch_we = 1'b1;
          ch_valid_d[ch_waddr] = 1'b1;
          for (int i = 0; i < 7; i++) begin
            v_d[i] = v_q[i + 1];
          end
        end
        if (cnt_q == 6'd8) begin
          cnt_d = '0;
          if (!eom_q) begin
            state_d = ST_IDLE;
          end else if (!padded_q) begin
            state_d  = ST_PAD;
            pidx_d   = fill_q[5:2];
            first_d  = 1'b1;
            padded_d = 1'b1;
            long_d   = (fill_q[5:3] == 3'd7);
          end else if (long_q && !pass2_q) begin
            state_d = ST_PAD;
            pass2_d = 1'b1;
            pidx_d  = '0;
            first_d = 1'b0;
          end else begin
            state_d = ST_OUT_RD;
          end
        end
      end

      ST_OUT_RD: begin
        state_d = ST_OUT_LD;
      end

      ST_OUT_LD: begin
        dw_d        = ch_rd;
        out_valid_d = 1'b1;
        state_d     = ST_OUT_WT;
      end

      ST_OUT_WT: begin
        if (out_done) begin
          out_valid_d = 1'b0;
          if (cnt_q[2:0] == 3'd7) begin
            // Message finished: back to the initial hash state.
            state_d    = ST_IDLE;
            cnt_d      = '0;
            ch_valid_d = '0;
            fill_d     = '0;
            bitlen_d   = '0;
            eom_d      = 1'b0;
            padded_d   = 1'b0;
            pass2_d    = 1'b0;
            long_d     = 1'b0;
          end else begin
            state_d = ST_OUT_RD;
            cnt_d   = cnt_q + 6'd1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      fill_q      <= '0;
      bitlen_q    <= '0;
      eom_q       <= 1'b0;
      padded_q    <= 1'b0;
      pass2_q     <= 1'b0;
      first_q     <= 1'b0;
      long_q      <= 1'b0;
      pidx_q      <= '0;
      ch_valid_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fill_q      <= fill_d;
      bitlen_q    <= bitlen_d;
      eom_q       <= eom_d;
      padded_q    <= padded_d;
      pass2_q     <= pass2_d;
      first_q     <= first_d;
      long_q      <= long_d;
      pidx_q      <= pidx_d;
      ch_valid_q  <= ch_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    w_q     <= w_d;
    dw_q    <= dw_d;
    v_q     <= v_d;
    sched_q <= sched_d;
  end

  `SHAMH_ASSERT_NOW(a_blk_wr_phase, blk_we, (state_q == ST_IDLE) || (state_q == ST_PAD), "block memory written during compression")
  `SHAMH_ASSERT_NOW(a_ch_rmw_apart, ch_we, ch_waddr != ch_raddr, "chain write and read hit the same entry")
  `SHAMH_ASSERT_NOW(a_out_in_wait, out_valid_q, (state_q == ST_OUT_WT) && !msg_i.ready, "digest word shown outside the output wait")
  `SHAMH_ASSERT_NEXT(a_reset_after_digest, out_done && (cnt_q[2:0] == 3'd7), (fill_q == 6'd0) && (bitlen_q == 64'd0) && (ch_valid_q == 8'd0), "hash state not restored after the last digest word")

endmodule
